// ===== sv/encoder_error_table_builder_macros.svh =====
// Assertion macros shared by the checker of the encoder error table builder
`ifndef ENCODER_ERROR_TABLE_BUILDER_MACROS_SVH
`define ENCODER_ERROR_TABLE_BUILDER_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset
`define EETB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("encoder error table builder: property violated");

// Next-cycle implication, sampled on the block clock, off during reset
`define EETB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("encoder error table builder: property violated");

`endif

// ===== sv/eetb_pkg.sv =====
// Shared types, widths and constants of the encoder error table builder
package eetb_pkg;

   localparam int ANGLE_W     = 16;
   localparam int SLOPE_W     = 24;
   localparam int WARMUP_W    = 17;
   localparam int REF_W       = 36;
   localparam int ERR_W       = 38;
   localparam int FILT_W      = 18;
   localparam int INDEX_W     = 10;
   localparam int TABLE_DEPTH = 1024;
   localparam int FRAC_BITS   = 8;
   localparam int BIN_LSB     = 6;
   localparam int BIN_MSB     = 15;
   localparam int DIFF_W      = ANGLE_W + 1;

   localparam int FILTER_DEPTH_DEF = 32;
   localparam int RAMP_BITS_DEF    = 20;

   localparam int WRAP_LIMIT = 60000;
   localparam int WRAP_SPAN  = 65535;
   localparam logic signed [DIFF_W-1:0] WRAP_LIMIT_S = 17'sd60000;
   localparam logic signed [DIFF_W-1:0] WRAP_SPAN_S  = 17'sd65535;

   localparam logic [WARMUP_W-1:0] WARMUP_RESET = 17'd100000;
   localparam logic [ANGLE_W-1:0]  START_LO     = 16'd1;
   localparam logic [ANGLE_W-1:0]  START_HI     = 16'd4;
   localparam logic [INDEX_W-1:0]  BIN_RESET    = 10'd1;
   localparam logic [INDEX_W-1:0]  LAST_SLOT    = INDEX_W'(TABLE_DEPTH - 1);

   localparam int REQ_W       = 16;
   localparam int RSP_W       = 112;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REF_SLOPE    = 1'b0,
      CSR_WARMUP_TICKS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH
   } fsm_state_type;

   // Control of one sample cell: parallel fill or one step along the ring
   typedef struct packed {
      logic load_all;
      logic step;
   } cell_ctl_type;

   // Result payload, last member in the lowest bits
   typedef struct packed {
      logic [6:0]              pad;
      logic                    table_ready;
      logic [INDEX_W-1:0]      table_index;
      logic                    table_write;
      logic signed [FILT_W-1:0] filtered_angle;
      logic signed [ERR_W-1:0] angle_error;
      logic [REF_W-1:0]        ref_angle;
      logic                    build_enabled;
   } rsp_data_type;

   // Sample minus angle, folded back across the 16-bit wrap
   function automatic logic signed [DIFF_W-1:0] wrap_diff(
      input logic [ANGLE_W-1:0] sample,
      input logic [ANGLE_W-1:0] angle
   );
      logic signed [DIFF_W-1:0] d;
      d = $signed({1'b0, sample}) - $signed({1'b0, angle});
      if (d > WRAP_LIMIT_S) begin
         d = d - WRAP_SPAN_S;
      end
      if (d < -WRAP_LIMIT_S) begin
         d = d + WRAP_SPAN_S;
      end
      return d;
   endfunction

endpackage

// ===== sv/encoder_error_table_builder.sv =====
// Encoder error table builder: one result per angle sample. Once the block is enabled an
// accepted angle is shifted into the filter ring, the ring makes one full rotation through
// the shared difference accumulator, the divide by FILTER_DEPTH is started and finished,
// the output register is loaded and the block returns to idle to take the next angle.
// Before the block is enabled an angle goes straight to the output register load. A result
// held in the output register stalls the following one only at its final load. The next
// angle is taken while the previous result still waits in the output register. Once
// warm-up has passed and an angle of 1..4 arrives the block stays enabled; each change of
// bits 15:6 of the filtered angle advances the slot index, and the result carries
// table_write with the slot and the error for an external table until slot 1023 has been
// written and table_ready rises.
module encoder_error_table_builder #(
   parameter int FILTER_DEPTH = eetb_pkg::FILTER_DEPTH_DEF,
   parameter int RAMP_BITS    = eetb_pkg::RAMP_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [eetb_pkg::REQ_W-1:0]           req_tdata,  // [15:0] mag_angle
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] build_enabled, [36:1] ref_angle, [74:37] angle_error, [92:75] filtered_angle,
   // [93] table_write, [103:94] table_index, [104] table_ready, [111:105] zero
   output logic [eetb_pkg::RSP_W-1:0]           rsp_tdata,
   input  logic                                 csr_we,
   input  logic [eetb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [eetb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CNT_W  = $clog2(FILTER_DEPTH);
   localparam int ACC_W  =
      $clog2(((2 ** eetb_pkg::ANGLE_W) - 1 + eetb_pkg::WRAP_LIMIT) * FILTER_DEPTH + 1) + 1;
   localparam int PROD_W = eetb_pkg::SLOPE_W + RAMP_BITS;
   localparam int SAT_LSB = eetb_pkg::REF_W + eetb_pkg::FRAC_BITS;
   localparam int EXT_W  = (PROD_W > SAT_LSB) ? PROD_W : SAT_LSB + 1;

   eetb_pkg::fsm_state_type fsm_state_ff, fsm_state_in;
   eetb_pkg::cell_ctl_type  cell_ctl;
   eetb_pkg::rsp_data_type  rsp_data_ff, rsp_next;

   logic [eetb_pkg::SLOPE_W-1:0]   slope_ff;
   logic [eetb_pkg::WARMUP_W-1:0]  warmup_ff;
   logic [eetb_pkg::WARMUP_W-1:0]  run_ff;
   logic [eetb_pkg::WARMUP_W-1:0]  run_next;
   logic                           enabled_ff;
   logic                           en_next;
   logic [RAMP_BITS-1:0]           ramp_ff;
   logic [RAMP_BITS-1:0]           ramp_next;
   logic [eetb_pkg::ANGLE_W-1:0]   prev_angle_ff;
   logic                           unprimed_ff;
   logic [eetb_pkg::INDEX_W-1:0]   prev_bin_ff;
   logic [eetb_pkg::INDEX_W-1:0]   slot_ff;
   logic                           ready_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic                           rsp_valid_ff;

   logic [eetb_pkg::ANGLE_W-1:0]   angle_ff;
   logic [PROD_W-1:0]              prod_ff;
   logic [eetb_pkg::REF_W-1:0]     ref_ff;
   logic signed [eetb_pkg::ERR_W-1:0] err_ff;
   logic signed [ACC_W-1:0]        acc_ff;

   logic                           req_accept;
   logic                           rsp_load;
   logic                           start_seen;
   logic                           ramp_drop;
   logic signed [eetb_pkg::DIFF_W-1:0] step_diff;
   logic signed [eetb_pkg::DIFF_W-1:0] head_diff;
   logic [EXT_W-1:0]               prod_ext;
   logic [eetb_pkg::REF_W-1:0]     ref_sat;
   logic                           div_start;
   logic                           div_done;
   logic signed [eetb_pkg::FILT_W-1:0] filt;
   logic [eetb_pkg::INDEX_W-1:0]   bin;
   logic                           bin_change;
   logic [eetb_pkg::ANGLE_W-1:0]   tail_value;
   logic [eetb_pkg::ANGLE_W-1:0]   sample [FILTER_DEPTH];

   // ---------------------------------------------------------------- sample ring
   // First angle fills the ring, later ones shift in at the tail; rotate while summing
   assign tail_value = (fsm_state_ff == eetb_pkg::ST_INSERT) ? angle_ff : sample[0];

   for (genvar g = 0; g < FILTER_DEPTH; g++) begin : g_cell
      logic [eetb_pkg::ANGLE_W-1:0] neighbor;
      if (g == FILTER_DEPTH - 1) begin : g_tail
         assign neighbor = tail_value;
      end else begin : g_body
         assign neighbor = sample[g + 1];
      end
      eetb_cell u_cell (
         .clock          (clock),
         .ctl            (cell_ctl),
         .fill_value     (angle_ff),
         .neighbor_value (neighbor),
         .sample         (sample[g])
      );
   end

   eetb_div #(
      .DIVISOR    (FILTER_DEPTH),
      .DIVIDEND_W (ACC_W),
      .QUOT_W     (eetb_pkg::FILT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .done     (div_done),
      .quotient (filt)
   );

   // ---------------------------------------------------------------- control
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      fsm_state_in = fsm_state_ff;
      cell_ctl     = '0;
      div_start    = 1'b0;
      req_tready   = 1'b0;
      rsp_load     = 1'b0;
      case (fsm_state_ff)
         eetb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               fsm_state_in = en_next ? eetb_pkg::ST_INSERT : eetb_pkg::ST_FINISH;
            end
         end
         eetb_pkg::ST_INSERT: begin
            cell_ctl.load_all = unprimed_ff;
            cell_ctl.step     = !unprimed_ff;
            fsm_state_in      = eetb_pkg::ST_SUM;
         end
         eetb_pkg::ST_SUM: begin
            cell_ctl.step = 1'b1;
            if (cnt_ff == CNT_W'(FILTER_DEPTH - 1)) begin
               fsm_state_in = eetb_pkg::ST_DIV_START;
            end
         end
         eetb_pkg::ST_DIV_START: begin
            div_start    = 1'b1;
            fsm_state_in = eetb_pkg::ST_DIV_WAIT;
         end
         eetb_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               fsm_state_in = eetb_pkg::ST_FINISH;
            end
         end
         eetb_pkg::ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               fsm_state_in = eetb_pkg::ST_IDLE;
            end
         end
         default: begin
            fsm_state_in = eetb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_state_ff <= eetb_pkg::ST_IDLE;
      end else begin
         fsm_state_ff <= fsm_state_in;
      end
   end

   // ---------------------------------------------------------------- datapath logic
   always_comb begin
      start_seen = (req_tdata[eetb_pkg::ANGLE_W-1:0] >= eetb_pkg::START_LO) &&
                   (req_tdata[eetb_pkg::ANGLE_W-1:0] <= eetb_pkg::START_HI);
      run_next   = (run_ff == '1) ? run_ff : run_ff + 1'b1;
      en_next    = enabled_ff || ((run_next > warmup_ff) && start_seen);

      step_diff  = $signed({1'b0, angle_ff}) - $signed({1'b0, prev_angle_ff});
      ramp_drop  = step_diff < -eetb_pkg::WRAP_LIMIT_S;
      if (ramp_drop) begin
         ramp_next = '0;
      end else if (ramp_ff == '1) begin
         ramp_next = ramp_ff;
      end else begin
         ramp_next = ramp_ff + 1'b1;
      end

      head_diff = eetb_pkg::wrap_diff(sample[0], angle_ff);

      prod_ext = EXT_W'(prod_ff);
      ref_sat  = (|prod_ext[EXT_W-1:SAT_LSB]) ? '1 :
                 prod_ext[SAT_LSB-1:eetb_pkg::FRAC_BITS];

      bin        = filt[eetb_pkg::BIN_MSB:eetb_pkg::BIN_LSB];
      bin_change = bin != prev_bin_ff;

      rsp_next               = '0;
      rsp_next.build_enabled = enabled_ff;
      rsp_next.table_ready   = ready_ff;
      if (enabled_ff) begin
         rsp_next.ref_angle      = ref_ff;
         rsp_next.angle_error    = err_ff;
         rsp_next.filtered_angle = filt;
         if (bin_change) begin
            rsp_next.table_index = slot_ff;
            rsp_next.table_write = !ready_ff;
            if (!ready_ff && (slot_ff == eetb_pkg::LAST_SLOT)) begin
               rsp_next.table_ready = 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff      <= '0;
         warmup_ff     <= eetb_pkg::WARMUP_RESET;
         run_ff        <= '0;
         enabled_ff    <= 1'b0;
         ramp_ff       <= '0;
         prev_angle_ff <= '0;
         unprimed_ff   <= 1'b1;
         prev_bin_ff   <= eetb_pkg::BIN_RESET;
         slot_ff       <= '0;
         ready_ff      <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               eetb_pkg::CSR_REF_SLOPE:    slope_ff  <= csr_wdata;
               eetb_pkg::CSR_WARMUP_TICKS: warmup_ff <= csr_wdata[eetb_pkg::WARMUP_W-1:0];
               default: begin
               end
            endcase
         end

         if (req_accept) begin
            run_ff     <= run_next;
            enabled_ff <= en_next;
         end

         if (fsm_state_ff == eetb_pkg::ST_INSERT) begin
            unprimed_ff   <= 1'b0;
            ramp_ff       <= ramp_next;
            prev_angle_ff <= angle_ff;
            cnt_ff        <= '0;
         end else if (fsm_state_ff == eetb_pkg::ST_SUM) begin
            cnt_ff <= cnt_ff + 1'b1;
         end

         // Advance the slot on every bin change; stop storing once ready
         if (rsp_load && enabled_ff) begin
            prev_bin_ff <= bin;
            if (bin_change) begin
               slot_ff <= slot_ff + 1'b1;
               if (!ready_ff && (slot_ff == eetb_pkg::LAST_SLOT)) begin
                  ready_ff <= 1'b1;
               end
            end
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         angle_ff <= req_tdata[eetb_pkg::ANGLE_W-1:0];
      end
      if (fsm_state_ff == eetb_pkg::ST_INSERT) begin
         // Product uses the ramp count from before this tick's update
         prod_ff <= PROD_W'(slope_ff) * PROD_W'(ramp_ff);
         acc_ff  <= ACC_W'(angle_ff * FILTER_DEPTH);
      end
      if (fsm_state_ff == eetb_pkg::ST_SUM) begin
         acc_ff <= acc_ff + ACC_W'(head_diff);
         if (cnt_ff == CNT_W'(0)) begin
            ref_ff <= ref_sat;
         end
         if (cnt_ff == CNT_W'(1)) begin
            err_ff <= eetb_pkg::ERR_W'(ref_ff) -
                      (eetb_pkg::ERR_W'(angle_ff) << eetb_pkg::FRAC_BITS);
         end
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sv/eetb_cell.sv =====
// One sample cell of the circular-mean filter ring
module eetb_cell (
   input  logic                              clock,
   input  eetb_pkg::cell_ctl_type            ctl,
   input  logic [eetb_pkg::ANGLE_W-1:0]      fill_value,
   input  logic [eetb_pkg::ANGLE_W-1:0]      neighbor_value,
   output logic [eetb_pkg::ANGLE_W-1:0]      sample
);

   logic [eetb_pkg::ANGLE_W-1:0] sample_ff;
   logic [eetb_pkg::ANGLE_W-1:0] sample_in;

   always_comb begin
      sample_in = sample_ff;
      if (ctl.load_all) begin
         sample_in = fill_value;
      end else if (ctl.step) begin
         sample_in = neighbor_value;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign sample = sample_ff;

endmodule

// ===== sv/eetb_div.sv =====
// Signed division by a constant, truncating toward zero, quotient registered in the cycle after start
module eetb_div #(
   parameter int DIVISOR    = eetb_pkg::FILTER_DEPTH_DEF,
   parameter int DIVIDEND_W = 23,
   parameter int QUOT_W     = eetb_pkg::FILT_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DIVIDEND_W-1:0] dividend,
   output logic                         done,
   output logic signed [QUOT_W-1:0]     quotient
);

   localparam int MAG_W = DIVIDEND_W - 1;
   localparam int SHIFT = $clog2(DIVISOR);

   logic                     neg_ff;
   logic                     done_ff;
   logic [MAG_W-1:0]         dq_ff;
   logic [MAG_W-1:0]         dq_in;
   logic [MAG_W-1:0]         mag;
   logic signed [QUOT_W-1:0] q_mag;

   assign mag = MAG_W'(dividend[DIVIDEND_W-1] ? -dividend : dividend);

   if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_shift
      assign dq_in = mag >> SHIFT;
   end else begin : g_recip
      localparam int RECIP_SHIFT = MAG_W + SHIFT;
      localparam int PROD_W      = 2 * MAG_W + 1;
      localparam longint unsigned RECIP =
         ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

      logic [PROD_W-1:0] prod;

      // Multiply by the reciprocal rounded up; exact for every magnitude below 2**MAG_W
      assign prod  = PROD_W'(mag) * PROD_W'(RECIP);
      assign dq_in = MAG_W'(prod[PROD_W-1:RECIP_SHIFT]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[DIVIDEND_W-1];
         dq_ff  <= dq_in;
      end
   end

   assign q_mag    = QUOT_W'(dq_ff);
   assign quotient = neg_ff ? -q_mag : q_mag;
   assign done     = done_ff;

endmodule

// ===== sv/eetb_checker.sv =====
// Port-level checker of the encoder error table builder, bound to the top level
`include "encoder_error_table_builder_macros.svh"

module eetb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [eetb_pkg::RSP_W-1:0]       rsp_tdata,
   input logic                             csr_we
);

   eetb_pkg::rsp_data_type rsp;
   logic                   seen_ready_ff;
   logic                   disabled_clean;
   logic                   last_slot_write;
   logic                   ready_clean;
   logic                   quiet;

   assign rsp = rsp_tdata;

   assign disabled_clean = rsp.ref_angle == '0 && rsp.angle_error == '0 &&
                           rsp.filtered_angle == '0 && !rsp.table_write &&
                           rsp.table_index == '0;
   assign last_slot_write = rsp_tvalid && rsp.table_write &&
                            rsp.table_index == eetb_pkg::LAST_SLOT;
   assign ready_clean     = rsp.table_ready && rsp.build_enabled && !rsp.table_write;
   assign quiet           = req_tready && !req_tvalid && !rsp_tvalid;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ready_ff <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready && rsp.table_ready) begin
            seen_ready_ff <= 1'b1;
         end
      end
   end

   `EETB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `EETB_ASSERT_IMPL(a_disabled_zero, rsp_tvalid && !rsp.build_enabled, disabled_clean)
   `EETB_ASSERT_IMPL(a_last_slot_ready, last_slot_write, rsp.table_ready)
   `EETB_ASSERT_IMPL(a_ready_sticky, rsp_tvalid && seen_ready_ff, ready_clean)
   `EETB_ASSERT_IMPL(a_cfg_when_idle, csr_we, quiet)

endmodule

bind encoder_error_table_builder eetb_checker u_eetb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_we     (csr_we)
);
